FILE: rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

    localparam int unsigned HEAD_BYTES_DEF   = 8;
    localparam int unsigned OFFSET_WIDTH_DEF = 20;
    localparam int unsigned LENGTH_WIDTH_DEF = 16;

    // field widths fixed by the token format
    localparam int unsigned CLASS_W = 6;
    localparam int unsigned OFF_W   = 20;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned LINE_W  = 16;

    // scanner states
    localparam logic [3:0] ST_BEGIN   = 4'd0;
    localparam logic [3:0] ST_WORD    = 4'd1;
    localparam logic [3:0] ST_INT     = 4'd2;
    localparam logic [3:0] ST_REAL    = 4'd3;
    localparam logic [3:0] ST_CHR     = 4'd4;
    localparam logic [3:0] ST_STR     = 4'd5;
    localparam logic [3:0] ST_PUNCT   = 4'd6;
    localparam logic [3:0] ST_CHR_ESC = 4'd7;
    localparam logic [3:0] ST_STR_ESC = 4'd8;

    // token classes
    localparam logic [5:0] CL_END   = 6'd0;
    localparam logic [5:0] CL_IDENT = 6'd1;
    localparam logic [5:0] CL_INT   = 6'd2;
    localparam logic [5:0] CL_REAL  = 6'd3;
    localparam logic [5:0] CL_CHR   = 6'd4;
    localparam logic [5:0] CL_STR   = 6'd5;

    localparam int unsigned LEX_N = 44;

    typedef struct packed {
        logic [63:0] txt;   // first byte in the low bits
        logic [3:0]  len;
        logic [5:0]  cls;
    } t_lex;

    function automatic logic [63:0] pk(input logic [63:0] s, input int unsigned n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
        end
        return r;
    endfunction

    function automatic t_lex lex_entry(input int unsigned i);
        t_lex e;
        e = '{txt: '0, len: 4'd0, cls: CL_IDENT};
        case (i)
            0:  e = '{pk("(", 1), 4'd1, 6'd6};
            1:  e = '{pk(")", 1), 4'd1, 6'd7};
            2:  e = '{pk("[", 1), 4'd1, 6'd8};
            3:  e = '{pk("]", 1), 4'd1, 6'd9};
            4:  e = '{pk("{", 1), 4'd1, 6'd10};
            5:  e = '{pk("}", 1), 4'd1, 6'd11};
            6:  e = '{pk("/*", 2), 4'd2, 6'd12};
            7:  e = '{pk("*/", 2), 4'd2, 6'd13};
            8:  e = '{pk("//", 2), 4'd2, 6'd14};
            9:  e = '{pk(",", 1), 4'd1, 6'd15};
            10: e = '{pk(";", 1), 4'd1, 6'd16};
            11: e = '{pk(".", 1), 4'd1, 6'd17};
            12: e = '{pk(":", 1), 4'd1, 6'd18};
            13: e = '{pk("+", 1), 4'd1, 6'd19};
            14: e = '{pk("-", 1), 4'd1, 6'd20};
            15: e = '{pk("/", 1), 4'd1, 6'd21};
            16: e = '{pk("*", 1), 4'd1, 6'd22};
            17: e = '{pk("=", 1), 4'd1, 6'd23};
            18: e = '{pk("==", 2), 4'd2, 6'd24};
            19: e = '{pk("!=", 2), 4'd2, 6'd25};
            20: e = '{pk("<", 1), 4'd1, 6'd26};
            21: e = '{pk(">", 1), 4'd1, 6'd27};
            22: e = '{pk("<=", 2), 4'd2, 6'd28};
            23: e = '{pk(">=", 2), 4'd2, 6'd29};
            24: e = '{pk("&&", 2), 4'd2, 6'd30};
            25: e = '{pk("||", 2), 4'd2, 6'd31};
            26: e = '{pk("[]", 2), 4'd2, 6'd32};
            27: e = '{pk("cast", 4), 4'd4, 6'd33};
            28: e = '{pk("new", 3), 4'd3, 6'd34};
            29: e = '{pk("free", 4), 4'd4, 6'd35};
            30: e = '{pk("verbatim", 8), 4'd8, 6'd36};
            31: e = '{pk("true", 4), 4'd4, 6'd37};
            32: e = '{pk("false", 5), 4'd5, 6'd38};
            33: e = '{pk("null", 4), 4'd4, 6'd39};
            34: e = '{pk("module", 6), 4'd6, 6'd40};
            35: e = '{pk("struct", 6), 4'd6, 6'd41};
            36: e = '{pk("enum", 4), 4'd4, 6'd42};
            37: e = '{pk("return", 6), 4'd6, 6'd43};
            38: e = '{pk("static", 6), 4'd6, 6'd44};
            39: e = '{pk("const", 5), 4'd5, 6'd45};
            40: e = '{pk("private", 7), 4'd7, 6'd46};
            41: e = '{pk("if", 2), 4'd2, 6'd47};
            42: e = '{pk("else", 4), 4'd4, 6'd48};
            43: e = '{pk("while", 5), 4'd5, 6'd49};
            default: e = '{txt: '0, len: 4'd0, cls: CL_IDENT};
        endcase
        return e;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_single(input logic [7:0] c);
        return c == "{" || c == "}" || c == "(" || c == ")" || c == ";" || c == "," ||
               c == "." || c == "+" || c == "-" || c == "^" || c == "~" || c == ":" ||
               c == 8'h0a;
    endfunction
    function automatic logic is_punct(input logic [7:0] c);
        return c == "<" || c == ">" || c == "=" || c == "[" || c == "]" ||
               c == "&" || c == "|" || c == "!" || c == "/" || c == "*";
    endfunction

endpackage
`default_nettype wire

FILE: rtl/source_text_tokenizer_unit.sv
// source text tokenizer
// s_axis: one source byte per word, tdata[7:0] = char_byte, tuser = end_of_text
//   (high on the final byte of a text)
// m_axis: one token per word, tdata = {line_number, content_length, content_offset,
//   token_class} packed from bit 0, tuser = last token caused by the byte
// a byte goes through the scanner logic in the cycle it is accepted; its up to
//   three tokens (flushed token, single-char token, end token) are loaded into a
//   three-entry result buffer and leave one per cycle, while the receiver is ready, from the next cycle on
// throughput: one byte per cycle while each byte gives at most one token and the
//   receiver is ready; a byte that gives more tokens holds the input until the
//   single output port is taking the last token of the result buffer
// s_axis_tready is high whenever the buffer is empty or its last token is being
//   taken this cycle, so a stalled receiver stalls the input without loss
// the keyword/symbol lookup is a parallel compare of the token head against a
//   constant table, done in the same cycle as the state update
// reset (synchronous, active low) returns the scanner to the begin state,
//   clears the byte position, line count and buffer
// after an end-of-text byte the scanner is back in its reset state
`default_nettype none
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int unsigned HEAD_BYTES   = HEAD_BYTES_DEF,
    parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_byte
    input  wire logic        s_axis_tuser,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // token_class, content_offset,
                                             // content_length, line_number, pad
    output logic             m_axis_tuser    // last_result
);

    localparam int unsigned HW = HEAD_BYTES * 8;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [OFF_W-1:0]   off;
        logic [LEN_W-1:0]   len;
        logic [LINE_W-1:0]  line;
        logic               last;
    } t_tok;

    logic [3:0]              r_state, n_state;
    logic [HW-1:0]           r_head, n_head;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [LINE_W-1:0]       r_line, n_line;

    t_tok       r_buf [3];
    t_tok       n_buf [3];
    logic [1:0] r_cnt, n_cnt;   // tokens waiting
    logic [1:0] r_rd, n_rd;     // next one to send

    logic       acc, take;
    logic [7:0] b;

    assign b     = s_axis_tdata;
    assign take  = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
    assign acc   = s_axis_tvalid && s_axis_tready;

    // class of a word/punct token from its kept head
    function automatic logic [5:0] lookup(input logic [HW-1:0] h,
                                          input logic [LENGTH_WIDTH-1:0] l);
        logic [5:0] c;
        t_lex       e;
        c = CL_IDENT;
        for (int i = LEX_N - 1; i >= 0; i--) begin
            e = lex_entry(i);
            if (l == LENGTH_WIDTH'(e.len) && h[63:0] == e.txt[63:0]) c = e.cls;
        end
        return c;
    endfunction

    function automatic logic [5:0] st_class(input logic [3:0] st, input logic [HW-1:0] h,
                                            input logic [LENGTH_WIDTH-1:0] l);
        logic [5:0] c;
        case (st)
            ST_INT:              c = CL_INT;
            ST_REAL:             c = CL_REAL;
            ST_CHR, ST_CHR_ESC:  c = CL_CHR;
            ST_STR, ST_STR_ESC:  c = CL_STR;
            default:             c = lookup(h, l);
        endcase
        return c;
    endfunction

    always_comb begin
        logic [3:0]              st;
        logic [HW-1:0]           hd;
        logic [LENGTH_WIDTH-1:0] ln;
        logic [OFFSET_WIDTH-1:0] sp;
        logic [LINE_W-1:0]       lc;
        logic                    redo, fin;
        t_tok                    tk [3];
        logic [1:0]              k;
        logic [OFFSET_WIDTH-1:0] np;

        st = r_state; hd = r_head; ln = r_len; sp = r_start; lc = r_line;
        redo = 1'b0; fin = 1'b0; k = 2'd0;
        for (int i = 0; i < 3; i++) tk[i] = '0;

        // main scanner step: fin marks finish of the current token
        case (r_state)
            ST_BEGIN: redo = 1'b1;
            ST_WORD: begin
                if (is_alpha(b) || is_digit(b) || b == "_") fin = 1'b0;
                else begin fin = 1'b1; redo = 1'b1; end
            end
            ST_INT: begin
                if (b == ".") st = ST_REAL;
                else if (!is_digit(b)) begin fin = 1'b1; redo = 1'b1; end
            end
            ST_REAL: if (!is_digit(b)) begin fin = 1'b1; redo = 1'b1; end
            ST_CHR: begin
                if (b == "'") fin = 1'b1;
                else if (b == 8'h5c) st = ST_CHR_ESC;
            end
            ST_STR: begin
                if (b == "\"") fin = 1'b1;
                else if (b == 8'h5c) st = ST_STR_ESC;
            end
            ST_CHR_ESC: st = ST_CHR;
            ST_STR_ESC: st = ST_STR;
            ST_PUNCT: begin
                if (b == "]") fin = 1'b1;
                else if (is_digit(b) || is_alpha(b) || is_single(b) || is_space(b)) begin
                    fin = 1'b1; redo = 1'b1;
                end
            end
            default: begin st = ST_BEGIN; redo = 1'b1; end
        endcase

        // append byte when the token continues (or closing bracket)
        if (!redo && !(fin && (r_state == ST_CHR || r_state == ST_STR))) begin
            for (int i = 0; i < HEAD_BYTES; i++)
                if (ln == LENGTH_WIDTH'(i)) hd[8*i +: 8] = b;
            if (ln != LEN_MAX) ln = ln + 1'b1;
        end

        if (fin) begin
            tk[k] = '{cls: st_class(st, hd, ln), off: OFF_W'(sp),
                      len: LEN_W'(ln), line: lc, last: 1'b0};
            k = k + 2'd1;
            st = ST_BEGIN; ln = '0; hd = '0;
        end

        if (redo) begin
            if (is_single(b)) begin
                if (b == 8'h0a) begin
                    if (lc != '1) lc = lc + 1'b1;
                end else begin
                    tk[k] = '{cls: lookup(HW'(b), LENGTH_WIDTH'(1)), off: OFF_W'(r_pos),
                              len: LEN_W'(1), line: lc, last: 1'b0};
                    k = k + 2'd1;
                    sp = r_pos; st = ST_BEGIN; ln = '0; hd = '0;
                end
            end else if (is_alpha(b) || is_digit(b) || is_punct(b)) begin
                st = is_alpha(b) ? ST_WORD : (is_digit(b) ? ST_INT : ST_PUNCT);
                sp = r_pos; hd = HW'(b); ln = LENGTH_WIDTH'(1);
            end else if (b == "'" || b == "\"") begin
                st = (b == "'") ? ST_CHR : ST_STR;
                sp = r_pos + 1'b1; hd = '0; ln = '0;
            end
        end

        np = r_pos + 1'b1;

        if (s_axis_tuser) begin
            if (st != ST_BEGIN && ln != '0) begin
                tk[k] = '{cls: st_class(st, hd, ln), off: OFF_W'(sp),
                          len: LEN_W'(ln), line: lc, last: 1'b0};
                k = k + 2'd1;
            end
            tk[k] = '{cls: CL_END, off: OFF_W'(np), len: '0, line: lc, last: 1'b0};
            k = k + 2'd1;
            st = ST_BEGIN; hd = '0; ln = '0; sp = '0; np = '0; lc = '0;
        end
        if (k != 2'd0) tk[k - 2'd1].last = 1'b1;

        n_state = r_state; n_head = r_head; n_len = r_len;
        n_start = r_start; n_pos = r_pos; n_line = r_line;
        n_buf = r_buf; n_cnt = r_cnt; n_rd = r_rd;
        if (take) begin
            n_cnt = r_cnt - 2'd1;
            n_rd  = (r_cnt == 2'd1) ? 2'd0 : r_rd + 2'd1;
        end
        if (acc) begin
            n_state = st; n_head = hd; n_len = ln;
            n_start = sp; n_pos = np; n_line = lc;
            n_buf = tk; n_cnt = k; n_rd = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BEGIN;
            r_head  <= '0;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= '0;
            r_cnt   <= 2'd0;
            r_rd    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
        end
        r_buf <= n_buf;
    end

    t_tok cur;
    assign cur = r_buf[r_rd];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {6'd0, cur.line, cur.len, cur.off, cur.cls};
    assign m_axis_tuser  = cur.last;

    // the last buffered token carries the last flag
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_cnt == 2'd1 |-> m_axis_tuser)
        else $error("last token not flagged");
    a_nolast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_cnt > 2'd1 |-> !m_axis_tuser)
        else $error("early last flag");
    a_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tuser |=> r_state == ST_BEGIN && r_pos == '0 && r_line == '0)
        else $error("scanner not cleared after end of text");

endmodule
`default_nettype wire

FILE: verif/tokenizer_checker.sv
`timescale 1ns / 1ps
module tokenizer_checker
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_eot,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_out_data,
    input  wire logic        i_out_last,
    output int               o_pending,
    output int               o_fail_count
);
    typedef struct packed {
        logic [5:0]  cls;
        logic [19:0] off;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    t_token token_q[$];
    logic [3:0]  scan;
    logic [7:0]  head[8];
    logic [15:0] tok_len;
    logic [19:0] tok_start;
    logic [19:0] byte_pos;
    logic [15:0] lines;
    int          step_count;

    function automatic logic alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic space_c(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic single_c(input logic [7:0] c);
        return c == "{" || c == "}" || c == "(" || c == ")" || c == ";" || c == "," ||
               c == "." || c == "+" || c == "-" || c == "^" || c == "~" || c == ":" ||
               c == 8'h0a;
    endfunction
    function automatic logic punct_c(input logic [7:0] c);
        return c == "<" || c == ">" || c == "=" || c == "[" || c == "]" ||
               c == "&" || c == "|" || c == "!" || c == "/" || c == "*";
    endfunction

    // keyword and symbol lookup on the kept head bytes
    function automatic logic [5:0] word_class();
        string s;
        s = "";
        if (tok_len > 8) return CL_IDENT;
        for (int i = 0; i < tok_len; i++) s = {s, string'(head[i])};
        if (s.len() != tok_len) return CL_IDENT;  // a zero byte never matches
        case (s)
            "(": return 6'd6;  ")": return 6'd7;  "[": return 6'd8;  "]": return 6'd9;
            "{": return 6'd10; "}": return 6'd11; "/*": return 6'd12; "*/": return 6'd13;
            "//": return 6'd14; ",": return 6'd15; ";": return 6'd16; ".": return 6'd17;
            ":": return 6'd18; "+": return 6'd19; "-": return 6'd20; "/": return 6'd21;
            "*": return 6'd22; "=": return 6'd23; "==": return 6'd24; "!=": return 6'd25;
            "<": return 6'd26; ">": return 6'd27; "<=": return 6'd28; ">=": return 6'd29;
            "&&": return 6'd30; "||": return 6'd31; "[]": return 6'd32;
            "cast": return 6'd33; "new": return 6'd34; "free": return 6'd35;
            "verbatim": return 6'd36; "true": return 6'd37; "false": return 6'd38;
            "null": return 6'd39; "module": return 6'd40; "struct": return 6'd41;
            "enum": return 6'd42; "return": return 6'd43; "static": return 6'd44;
            "const": return 6'd45; "private": return 6'd46; "if": return 6'd47;
            "else": return 6'd48; "while": return 6'd49;
            default: return CL_IDENT;
        endcase
    endfunction

    task automatic push_token(input logic [5:0] c, input logic [19:0] o, input logic [15:0] l);
        t_token t;
        t = '{cls: c, off: o, len: l, line: lines, last: 1'b0};
        token_q.push_back(t);
        step_count++;
    endtask

    task automatic flush_token();
        logic [5:0] c;
        case (scan)
            ST_INT: c = CL_INT;
            ST_REAL: c = CL_REAL;
            ST_CHR, ST_CHR_ESC: c = CL_CHR;
            ST_STR, ST_STR_ESC: c = CL_STR;
            default: c = word_class();
        endcase
        push_token(c, tok_start, tok_len);
        scan = ST_BEGIN;
        tok_len = 0;
        head = '{default: 8'h00};
    endtask

    task automatic add_byte(input logic [7:0] b);
        if (tok_len < 8) head[tok_len[2:0]] = b;
        if (tok_len != 16'hffff) tok_len++;
    endtask

    task automatic start_token(input logic [3:0] st, input logic [19:0] at,
                               input logic [7:0] b, input logic keep);
        scan = st;
        tok_start = at;
        tok_len = 0;
        head = '{default: 8'h00};
        if (keep) add_byte(b);
    endtask

    task automatic clear_scanner();
        scan = ST_BEGIN;
        head = '{default: 8'h00};
        tok_len = 0;
        tok_start = 0;
        byte_pos = 0;
        lines = 0;
    endtask

    // scanner step for one source byte, queues the tokens it finishes
    task automatic predict_tokens(input logic [7:0] b, input logic eot);
        logic redo;
        t_token t;
        redo = 1'b0;
        step_count = 0;
        case (scan)
            ST_BEGIN: redo = 1'b1;
            ST_WORD:
                if (alpha_c(b) || digit_c(b) || b == "_") add_byte(b);
                else begin flush_token(); redo = 1'b1; end
            ST_INT:
                if (b == ".") begin add_byte(b); scan = ST_REAL; end
                else if (digit_c(b)) add_byte(b);
                else begin flush_token(); redo = 1'b1; end
            ST_REAL:
                if (digit_c(b)) add_byte(b);
                else begin flush_token(); redo = 1'b1; end
            ST_CHR:
                if (b == "'") flush_token();
                else begin add_byte(b); if (b == "\\") scan = ST_CHR_ESC; end
            ST_STR:
                if (b == "\"") flush_token();
                else begin add_byte(b); if (b == "\\") scan = ST_STR_ESC; end
            ST_CHR_ESC: begin add_byte(b); scan = ST_CHR; end
            ST_STR_ESC: begin add_byte(b); scan = ST_STR; end
            ST_PUNCT:
                if (b == "]") begin add_byte(b); flush_token(); end
                else if (digit_c(b) || alpha_c(b) || single_c(b) || space_c(b)) begin
                    flush_token();
                    redo = 1'b1;
                end else add_byte(b);
            default: begin scan = ST_BEGIN; redo = 1'b1; end
        endcase
        if (redo) begin
            if (single_c(b)) begin
                if (b == 8'h0a) begin
                    if (lines != 16'hffff) lines++;
                end else begin
                    start_token(ST_PUNCT, byte_pos, b, 1'b1);
                    flush_token();
                end
            end else if (alpha_c(b)) start_token(ST_WORD, byte_pos, b, 1'b1);
            else if (digit_c(b)) start_token(ST_INT, byte_pos, b, 1'b1);
            else if (b == "'") start_token(ST_CHR, byte_pos + 20'd1, b, 1'b0);
            else if (b == "\"") start_token(ST_STR, byte_pos + 20'd1, b, 1'b0);
            else if (punct_c(b)) start_token(ST_PUNCT, byte_pos, b, 1'b1);
        end
        byte_pos = byte_pos + 20'd1;
        if (eot) begin
            if (scan != ST_BEGIN && tok_len != 0) flush_token();
            push_token(CL_END, byte_pos, 16'd0);
            clear_scanner();
        end
        if (step_count > 0) begin
            t = token_q.pop_back();
            t.last = 1'b1;
            token_q.push_back(t);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: token %s mismatch: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = token_q.size();

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            clear_scanner();
            token_q.delete();
            o_fail_count = 0;
        end else begin
            // compare first, the result of a byte never leaves in its own cycle
            if (i_out_valid && i_out_ready) begin
                if (token_q.size() == 0) begin
                    report_mismatch("unexpected", i_out_data, 64'd0);
                end else begin
                    want = token_q.pop_front();
                    if (i_out_data[5:0] != want.cls)
                        report_mismatch("class", i_out_data[5:0], want.cls);
                    if (i_out_data[25:6] != want.off)
                        report_mismatch("offset", i_out_data[25:6], want.off);
                    if (i_out_data[41:26] != want.len)
                        report_mismatch("length", i_out_data[41:26], want.len);
                    if (i_out_data[57:42] != want.line)
                        report_mismatch("line", i_out_data[57:42], want.line);
                    if (i_out_last != want.last)
                        report_mismatch("last flag", i_out_last, want.last);
                end
            end
            if (i_in_valid && i_in_ready) predict_tokens(i_in_byte, i_in_eot);
        end
    end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          sent;

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    source_text_tokenizer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // char_byte
        .s_axis_tuser  (s_tuser),   // end_of_text
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // class, offset, length, line, pad
        .m_axis_tuser  (m_tuser)    // last token of the byte
    );

    tokenizer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_byte    (s_tdata),
        .i_in_eot     (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_last   (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // receiver stalls at random, changed on the falling edge
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one source word, with a random gap before it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = eot;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        sent++;
    endtask

    task automatic send_text(input string s, input logic eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    function automatic string random_word(input int n, input logic numeric);
        string s;
        logic [7:0] c;
        s = "";
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: c = numeric ? 8'("0" + $urandom_range(9)) : 8'("A" + $urandom_range(25));
                1: c = 8'("0" + $urandom_range(9));
                2: c = numeric ? 8'("0" + $urandom_range(9)) : "_";
                default: c = 8'("a" + $urandom_range(25));
            endcase
            if (i == 0 && !numeric) c = 8'("a" + $urandom_range(25));
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // mostly well formed source fragments, some noise
    function automatic string random_fragment();
        string kw[17] = '{"cast", "new", "free", "verbatim", "true", "false", "null",
                          "module", "struct", "enum", "return", "static", "const",
                          "private", "if", "else", "while"};
        string sym[20] = '{"==", "!=", "<=", ">=", "&&", "||", "[]", "/*", "*/", "//",
                           "(", ")", "{", "}", ";", ",", ".", ":", "^~", "[x]]"};
        case ($urandom_range(11))
            0, 1: return kw[$urandom_range(16)];
            2:    return sym[$urandom_range(19)];
            3:    return random_word($urandom_range(1, 12), 1'b0);
            4:    return random_word($urandom_range(1, 5), 1'b1);
            5:    return {random_word($urandom_range(1, 3), 1'b1), ".",
                          random_word($urandom_range(0, 3), 1'b1)};
            6:    return $urandom_range(1) ? "'a'" : "'\\''";
            7:    return {"\"", random_word($urandom_range(0, 10), 1'b0), "\\\"\n\""};
            8:    return "\n";
            9:    return $urandom_range(1) ? " " : "\t";
            10:   return "<=>!&|*/";
            default: return string'(8'($urandom_range(1, 255)));
        endcase
    endfunction

    task automatic random_phase(input int s_pct, input int r_pct, input int n);
        int stop;
        logic eot;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop = sent + n;
        while (sent < stop) begin
            if ($urandom_range(9) == 0) begin
                // a raw byte with its end flag drawn at random
                eot = ($urandom_range(7) == 0);
                send_byte(8'($urandom), eot);
            end else begin
                send_text(random_fragment(), 1'b0);
                if ($urandom_range(1)) send_byte(" ", ($urandom_range(14) == 0));
            end
        end
        send_byte(" ", 1'b1);
    endtask

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: keyword, compare, real, escaped literals, newline, long word,
        // unknown single chars, high and zero bytes, unterminated string at end
        send_text("if x==1.5'\\''\"a\\\"\"\n[]verbatimx ^~", 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("7.\"ab", 1'b1);
        send_byte(" ", 1'b1);   // empty text, end token only
        send_byte("a", 1'b1);

        // random part in three idling modes
        random_phase(26, 72, 35);
        random_phase(72, 26, 35);
        random_phase(0, 0, 35);

        wait (pending == 0);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
